[sv/trd_pkg.sv]
`timescale 1ns / 1ps

package trd_pkg;

    localparam int SYMBOL_W   = 3;
    localparam int IN_DATA_W  = 8;
    localparam int END_POS_W  = 32;
    localparam int TOTAL_W    = 24;
    localparam int UNIT_OUT_W = 5;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 16;
    localparam int USIZE_W    = 5;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]   MIN_TOTAL_RST = 16'd12;
    localparam logic [LEN_W-1:0]   MIN_COUNT_RST = 16'd3;
    localparam logic [USIZE_W-1:0] MIN_UNIT_RST  = 5'd1;
    localparam logic [USIZE_W-1:0] WINDOW_RST    = 5'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TOTAL_LENGTH = 8'd0,
        CFG_MIN_UNIT_COUNT   = 8'd1,
        CFG_MIN_UNIT_SIZE    = 8'd2,
        CFG_WINDOW_SIZE      = 8'd3
    } cfg_reg_t;

    // Packed from the top bit down: the end position lands in the lowest bits
    typedef struct packed {
        logic [OUT_DATA_W-END_POS_W-TOTAL_W-UNIT_OUT_W-1:0] pad;
        logic [UNIT_OUT_W-1:0]                               unit_size;
        logic [TOTAL_W-1:0]                                  repeat_total;
        logic [END_POS_W-1:0]                                end_position;
    } result_t;

endpackage

[sv/tandem_repeat_detector_top.sv]
`timescale 1ns / 1ps

// The record for the beat that closes a repeat appears on m_axis in the cycle after
// that beat is accepted. Throughput: one symbol per cycle; s_axis_tready drops only while
// a finished record waits on m_axis. The lag compare array and the close check sit
// between the history shift register and the result register.
// Reset (aresetn low, synchronous) clears tracking, counters, position and the output
// valid, and loads the configuration defaults; no clearing pass is needed.
module tandem_repeat_detector_top #(
    parameter int MAX_UNIT = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_axis_tdata: [2:0] symbol, [7:3] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [trd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tlast,
    // m_axis_tdata: [31:0] end_position, [55:32] repeat_total, [60:56] unit_size, [63:61] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [trd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import trd_pkg::*;

    localparam int HIST_DEPTH = 2 * MAX_UNIT;
    localparam int LAG_W      = $clog2(MAX_UNIT + 1);
    localparam int VR_W       = $clog2(HIST_DEPTH + 1);
    localparam int VRX_W      = VR_W + 1;
    localparam int SUM_W      = TOTAL_W + 1;
    localparam int PROD_W     = LEN_W + LAG_W;
    localparam int CMP_W      = (PROD_W > TOTAL_W) ? PROD_W : TOTAL_W;
    localparam int LCMP_W     = (LAG_W > USIZE_W) ? LAG_W : USIZE_W;

    // Configuration
    logic [LEN_W-1:0]   min_total_reg;
    logic [LEN_W-1:0]   min_count_reg;
    logic [USIZE_W-1:0] min_unit_reg;
    logic [USIZE_W-1:0] window_reg;

    // Detector state
    logic [1:0]           hist_reg [HIST_DEPTH];
    logic [VR_W-1:0]      valid_run_reg, valid_run_next;
    logic                 tracking_reg, tracking_next;
    logic [LAG_W-1:0]     unit_reg, unit_next;
    logic [TOTAL_W-1:0]   count_reg, count_next;
    logic [END_POS_W-1:0] position_reg, position_next;

    // Output stage
    logic    m_valid_reg, m_valid_next;
    result_t result_reg;

    logic                 s_accept;
    logic [SYMBOL_W-1:0]  sym;
    logic                 sym_ok;
    logic [LAG_W-1:0]     w;
    logic [1:0]           hist_new [HIST_DEPTH];
    logic [VR_W-1:0]      vr_inc;
    logic [MAX_UNIT:0]    match_vec;
    logic                 open_any;
    logic [LAG_W-1:0]     open_lag;
    logic                 track_match;

    logic                 close_now;
    logic                 close_last;
    logic [LAG_W-1:0]     close_lag;
    logic [TOTAL_W-1:0]   close_count;
    logic [END_POS_W-1:0] close_pos;
    logic [SUM_W-1:0]     total_sum;
    logic [TOTAL_W-1:0]   total_sat;
    logic [PROD_W-1:0]    unit_prod;
    logic                 rec_valid;

    assign sym           = s_axis_tdata[SYMBOL_W-1:0];
    assign sym_ok        = ~sym[SYMBOL_W-1];
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ~m_valid_reg | m_axis_tready;
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = result_reg;

    // Effective window: zero acts as one, clamp to MAX_UNIT
    always_comb begin
        if (window_reg == '0) begin
            w = LAG_W'(1);
        end else if (32'(window_reg) > MAX_UNIT) begin
            w = LAG_W'(MAX_UNIT);
        end else begin
            w = LAG_W'(window_reg);
        end
    end

    // History as it stands after shifting in this symbol
    always_comb begin
        hist_new[0] = sym[1:0];
        for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_new[i] = hist_reg[i-1];
        end
    end

    assign vr_inc = (32'(valid_run_reg) == HIST_DEPTH) ? valid_run_reg
                                                        : valid_run_reg + VR_W'(1);

    // Compare the window against every lag in parallel
    always_comb begin
        logic lag_ok;
        match_vec = '0;
        for (int l = 1; l <= MAX_UNIT; l++) begin
            lag_ok = ({1'b0, vr_inc} >= (VRX_W'(w) + VRX_W'(l)));
            for (int k = 0; k < MAX_UNIT; k++) begin
                if ((LAG_W'(k) < w) && (hist_new[k] != hist_new[k+l])) begin
                    lag_ok = 1'b0;
                end
            end
            match_vec[l] = lag_ok;
        end
    end

    // Smallest matching lag within the window opens a repeat
    always_comb begin
        open_any = 1'b0;
        open_lag = '0;
        for (int l = MAX_UNIT; l >= 1; l--) begin
            if (match_vec[l] && (LAG_W'(l) <= w)) begin
                open_any = 1'b1;
                open_lag = LAG_W'(l);
            end
        end
    end

    assign track_match = match_vec[unit_reg];

    // Per-symbol state update
    always_comb begin
        tracking_next  = tracking_reg;
        unit_next      = unit_reg;
        count_next     = count_reg;
        valid_run_next = valid_run_reg;
        close_now      = 1'b0;
        if (!sym_ok) begin
            close_now      = tracking_reg;
            tracking_next  = 1'b0;
            unit_next      = '0;
            count_next     = '0;
            valid_run_next = '0;
        end else begin
            valid_run_next = vr_inc;
            if (tracking_reg) begin
                if (track_match) begin
                    if (count_reg != TOTAL_MAX) begin
                        count_next = count_reg + TOTAL_W'(1);
                    end
                end else begin
                    close_now     = 1'b1;
                    tracking_next = 1'b0;
                    unit_next     = '0;
                    count_next    = '0;
                end
            end else if (open_any) begin
                tracking_next = 1'b1;
                unit_next     = open_lag;
                count_next    = TOTAL_W'(1);
            end
        end

        // Sequence end closes whatever is still open with the updated state
        close_last  = s_axis_tlast & tracking_next;
        close_lag   = close_now ? unit_reg : unit_next;
        close_count = close_now ? count_reg : count_next;
        close_pos   = close_now ? position_reg : position_reg + END_POS_W'(1);

        if (s_axis_tlast) begin
            tracking_next  = 1'b0;
            unit_next      = '0;
            count_next     = '0;
            valid_run_next = '0;
            position_next  = '0;
        end else begin
            position_next  = position_reg + END_POS_W'(1);
        end
    end

    assign total_sum = SUM_W'(close_count) + SUM_W'(w) + SUM_W'(close_lag) - SUM_W'(1);
    assign total_sat = total_sum[SUM_W-1] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign unit_prod = PROD_W'(min_count_reg) * PROD_W'(close_lag);

    assign rec_valid = (close_now | close_last)
                     & (LCMP_W'(close_lag) >= LCMP_W'(min_unit_reg))
                     & (total_sat >= TOTAL_W'(min_total_reg))
                     & (CMP_W'(total_sat) >= CMP_W'(unit_prod));

    assign m_valid_next = s_accept ? rec_valid : (m_valid_reg & ~m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_total_reg <= MIN_TOTAL_RST;
            min_count_reg <= MIN_COUNT_RST;
            min_unit_reg  <= MIN_UNIT_RST;
            window_reg    <= WINDOW_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_MIN_TOTAL_LENGTH: min_total_reg <= cfg_data;
                CFG_MIN_UNIT_COUNT:   min_count_reg <= cfg_data;
                CFG_MIN_UNIT_SIZE:    min_unit_reg  <= cfg_data[USIZE_W-1:0];
                CFG_WINDOW_SIZE:      window_reg    <= cfg_data[USIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_run_reg <= '0;
            tracking_reg  <= 1'b0;
            unit_reg      <= '0;
            count_reg     <= '0;
            position_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                valid_run_reg <= valid_run_next;
                tracking_reg  <= tracking_next;
                unit_reg      <= unit_next;
                count_reg     <= count_next;
                position_reg  <= position_next;
            end
        end
    end

    // History contents beyond valid_run are never compared, so no reset is needed
    always_ff @(posedge aclk) begin
        if (s_accept && sym_ok) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= hist_new[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && rec_valid) begin
            result_reg.pad          <= '0;
            result_reg.unit_size    <= UNIT_OUT_W'(close_lag);
            result_reg.repeat_total <= total_sat;
            result_reg.end_position <= close_pos;
        end
    end

    a_track_has_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        tracking_reg |-> (unit_reg != '0) && (count_reg != '0))
        else $error("tracking without a unit or a count");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !tracking_reg |-> (unit_reg == '0) && (count_reg == '0))
        else $error("idle detector holds stale repeat state");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(valid_run_reg) <= HIST_DEPTH)
        else $error("valid run beyond history depth");

    a_seq_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tlast) |=> (position_reg == '0) && !tracking_reg)
        else $error("sequence end did not restart position and tracking");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while a record is stalled");

endmodule
